### design/rgh_pkg.sv
// shared types and constants for the rgb/gray histogram engine
package rgh_pkg;

	localparam int BINS_DEF       = 256;
	localparam int COUNT_BITS_DEF = 24;
	localparam int RATE_W         = 17;
	localparam int QDEPTH         = 4;

	localparam logic [RATE_W-1:0] RED_RATE_RST   = 17'd19595;
	localparam logic [RATE_W-1:0] GREEN_RATE_RST = 17'd38470;
	localparam logic [RATE_W-1:0] BLUE_RATE_RST  = 17'd7471;

	localparam logic [1:0] CFG_RED   = 2'd0;
	localparam logic [1:0] CFG_GREEN = 2'd1;
	localparam logic [1:0] CFG_BLUE  = 2'd2;
	localparam logic [1:0] CFG_NONE  = 2'd3;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_PIXEL = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [1:0] channel;
		logic [7:0] bin_low;
		logic [7:0] bin_high;
	} in_item_t;

	typedef struct packed {
		logic [23:0] range_count;
		logic [31:0] intensity_sum;
		logic [23:0] cumulative_count;
		logic [23:0] total_pixels;
	} out_item_t;

	// classified command handed from front to back; bins already clamped,
	// gray already computed
	typedef struct packed {
		kind_t      kind;
		logic [7:0] bin_r;
		logic [7:0] bin_g;
		logic [7:0] bin_b;
		logic [7:0] bin_y;
		logic [1:0] channel;
		logic [7:0] lo;
		logic [7:0] hi;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX,
		ST_QRD,
		ST_QACC,
		ST_QOUT
	} bstate_t;

endpackage

### design/rgb_gray_histogram_engine.sv
// top level: rgb and gray histogram engine with range queries
// throughput: the back end reads then writes the bin memories for a pixel
//   item and takes no new item until the write; a query scans bins
//   0..bin_high one per cycle
// reset: clears rate registers to luma weights, then sweeps all BINS bins
//   zeroing the bin memories; a clear item repeats that sweep
module rgb_gray_histogram_engine #(
	parameter int BINS       = rgh_pkg::BINS_DEF,
	parameter int COUNT_BITS = rgh_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rgh_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rgh_pkg::out_item_t         out_data,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [rgh_pkg::RATE_W-1:0] cfg_data
);
	// rate registers
	logic [rgh_pkg::RATE_W-1:0] red_rate_q, green_rate_q, blue_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_rate_q   <= rgh_pkg::RED_RATE_RST;
			green_rate_q <= rgh_pkg::GREEN_RATE_RST;
			blue_rate_q  <= rgh_pkg::BLUE_RATE_RST;
		end else if (cfg_we) begin
			// index above blue rate does nothing
			unique case (cfg_index)
				rgh_pkg::CFG_RED:   red_rate_q   <= cfg_data;
				rgh_pkg::CFG_GREEN: green_rate_q <= cfg_data;
				rgh_pkg::CFG_BLUE:  blue_rate_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front to queue
	logic          f_valid, f_ready;
	rgh_pkg::cmd_t f_cmd;
	// queue to back
	logic          b_valid, b_ready;
	rgh_pkg::cmd_t b_cmd;
	logic          busy;

	rgh_front #(.BINS(BINS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.red_rate(red_rate_q), .green_rate(green_rate_q), .blue_rate(blue_rate_q),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	rgh_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	rgh_back #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.busy(busy)
	);

	// back end takes no command while busy (sweeping, updating, scanning or presenting)
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !b_ready) else $error("command taken while back end busy");

	// a result only leaves after the back end has been busy
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(busy)) else $error("result without query");

	// front holds its command while the queue is full
	a_queue_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && !f_ready) |=> f_valid) else $error("front command lost");
endmodule

### design/rgh_front.sv
// front end: gray weighting, bin clamping and command classification
module rgh_front #(
	parameter int BINS = rgh_pkg::BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rgh_pkg::in_item_t           in_data,
	input  logic [rgh_pkg::RATE_W-1:0]  red_rate,
	input  logic [rgh_pkg::RATE_W-1:0]  green_rate,
	input  logic [rgh_pkg::RATE_W-1:0]  blue_rate,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output rgh_pkg::cmd_t               cmd
);
	localparam logic [7:0] TOPB = 8'(((BINS > 256) ? 256 : BINS) - 1);

	// stage 1: products registered
	logic              v_s1;
	rgh_pkg::in_item_t d_s1;
	logic [24:0]       pr_s1, pg_s1, pb_s1;
	logic              adv;

	assign adv      = !cmd_valid || cmd_ready;
	assign in_ready = !v_s1 || adv;

	function automatic logic [7:0] clampb(input logic [25:0] v);
		clampb = (v > 26'(TOPB)) ? TOPB : v[7:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			cmd_valid <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv) cmd_valid <= v_s1 && (d_s1.kind != rgh_pkg::KIND_NONE);
		end
	end

	logic [26:0] wsum;
	assign wsum = 27'(pr_s1) + 27'(pg_s1) + 27'(pb_s1);

	always_ff @(posedge clk) begin
		if (in_ready) begin
			d_s1  <= in_data;
			pr_s1 <= 25'(in_data.red)   * 25'(red_rate);
			pg_s1 <= 25'(in_data.green) * 25'(green_rate);
			pb_s1 <= 25'(in_data.blue)  * 25'(blue_rate);
		end
		if (adv) begin
			cmd.kind    <= rgh_pkg::kind_t'(d_s1.kind);
			cmd.bin_r   <= clampb(26'(d_s1.red));
			cmd.bin_g   <= clampb(26'(d_s1.green));
			cmd.bin_b   <= clampb(26'(d_s1.blue));
			cmd.bin_y   <= (wsum[26:16] > 11'(TOPB)) ? TOPB : wsum[23:16];
			cmd.channel <= d_s1.channel;
			cmd.lo      <= clampb(26'(d_s1.bin_low));
			cmd.hi      <= clampb(26'(d_s1.bin_high));
		end
	end
endmodule

### design/rgh_queue.sv
// small fifo of classified commands between front and back
module rgh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  rgh_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output rgh_pkg::cmd_t rd_data
);
	localparam int AW = $clog2(rgh_pkg::QDEPTH);

	rgh_pkg::cmd_t mem_q [rgh_pkg::QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign wr_ready = (cnt_q != (AW+1)'(rgh_pkg::QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

### design/rgh_back.sv
// back end: bin memory, clear sweep, increments and range scans
module rgh_back #(
	parameter int BINS       = rgh_pkg::BINS_DEF,
	parameter int COUNT_BITS = rgh_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  rgh_pkg::cmd_t      cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output rgh_pkg::out_item_t out_data,
	output logic               busy
);
	localparam int AW   = $clog2(BINS);
	localparam int CW   = COUNT_BITS;
	localparam logic [CW-1:0] CMAX = '1;
	localparam logic [AW-1:0] LAST = AW'(BINS - 1);

	// one memory per channel, rows are bins
	logic [CW-1:0] mem_r [BINS];
	logic [CW-1:0] mem_g [BINS];
	logic [CW-1:0] mem_b [BINS];
	logic [CW-1:0] mem_y [BINS];

	rgh_pkg::bstate_t st_q, st_d;
	rgh_pkg::cmd_t    c_q;
	logic [AW-1:0]    idx_q, idx_d;
	logic [CW-1:0]    tot_q;
	logic [24:0]      rng_q, cum_q;
	logic [32:0]      int_q;
	logic             take;

	// read port data, registered
	logic [CW-1:0] rd_r, rd_g, rd_b, rd_y;
	logic [AW-1:0] ra, idx_rd_q;
	logic          rvalid_q;

	logic          we;
	logic [AW-1:0] wa;
	logic [CW-1:0] wr_r, wr_g, wr_b, wr_y;

	function automatic logic [CW-1:0] inc(input logic [CW-1:0] v);
		inc = (v == CMAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [AW-1:0] bidx(input logic [7:0] v);
		bidx = AW'(v);
	endfunction

	assign busy = (st_q != rgh_pkg::ST_IDLE);
	assign take = cmd_valid && cmd_ready;

	// sequencer
	always_comb begin
		st_d      = st_q;
		idx_d     = idx_q;
		cmd_ready = 1'b0;
		ra        = idx_q;
		we        = 1'b0;
		wa        = idx_q;
		wr_r = '0; wr_g = '0; wr_b = '0; wr_y = '0;
		unique case (st_q)
			rgh_pkg::ST_CLEAR: begin
				we    = 1'b1;
				idx_d = idx_q + 1'b1;
				if (idx_q == LAST) st_d = rgh_pkg::ST_IDLE;
			end
			rgh_pkg::ST_IDLE: begin
				cmd_ready = !out_valid;
				if (take) begin
					case (cmd.kind)
						rgh_pkg::KIND_CLEAR: begin
							st_d  = rgh_pkg::ST_CLEAR;
							idx_d = '0;
						end
						rgh_pkg::KIND_PIXEL: st_d = rgh_pkg::ST_PIX;
						rgh_pkg::KIND_QUERY: begin
							st_d  = rgh_pkg::ST_QRD;
							idx_d = '0;
						end
						default: st_d = rgh_pkg::ST_IDLE;
					endcase
				end
			end
			rgh_pkg::ST_PIX: begin
				// each memory read at its own bin last cycle
				st_d = rgh_pkg::ST_IDLE;
			end
			rgh_pkg::ST_QRD: begin
				ra    = '0;
				idx_d = AW'(1);
				st_d  = rgh_pkg::ST_QACC;
			end
			rgh_pkg::ST_QACC: begin
				ra    = idx_q;
				idx_d = idx_q + 1'b1;
				if (idx_rd_q == bidx(c_q.hi)) st_d = rgh_pkg::ST_QOUT;
			end
			rgh_pkg::ST_QOUT: st_d = rgh_pkg::ST_IDLE;
			default: st_d = rgh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= rgh_pkg::ST_CLEAR;
			idx_q     <= '0;
			tot_q     <= '0;
			out_valid <= 1'b0;
			rvalid_q  <= 1'b0;
		end else begin
			st_q     <= st_d;
			idx_q    <= idx_d;
			rvalid_q <= (st_q == rgh_pkg::ST_QRD) || (st_q == rgh_pkg::ST_QACC);
			if (take && cmd.kind == rgh_pkg::KIND_CLEAR) tot_q <= '0;
			else if (take && cmd.kind == rgh_pkg::KIND_PIXEL) tot_q <= inc(tot_q);
			if (out_valid && out_ready) out_valid <= 1'b0;
			else if (st_q == rgh_pkg::ST_QOUT) out_valid <= 1'b1;
		end
	end

	// memory ports: pixel reads each channel at its own bin, query scans bins 0..hi
	logic [AW-1:0] ar, ag, ab, ay;
	assign ar = (st_q == rgh_pkg::ST_IDLE) ? bidx(cmd.bin_r) : ra;
	assign ag = (st_q == rgh_pkg::ST_IDLE) ? bidx(cmd.bin_g) : ra;
	assign ab = (st_q == rgh_pkg::ST_IDLE) ? bidx(cmd.bin_b) : ra;
	assign ay = (st_q == rgh_pkg::ST_IDLE) ? bidx(cmd.bin_y) : ra;

	always_ff @(posedge clk) begin
		rd_r <= mem_r[ar];
		rd_g <= mem_g[ag];
		rd_b <= mem_b[ab];
		rd_y <= mem_y[ay];
		if (we) begin
			mem_r[wa] <= wr_r;
			mem_g[wa] <= wr_g;
			mem_b[wa] <= wr_b;
			mem_y[wa] <= wr_y;
		end else if (st_q == rgh_pkg::ST_PIX) begin
			mem_r[bidx(c_q.bin_r)] <= inc(rd_r);
			mem_g[bidx(c_q.bin_g)] <= inc(rd_g);
			mem_b[bidx(c_q.bin_b)] <= inc(rd_b);
			mem_y[bidx(c_q.bin_y)] <= inc(rd_y);
		end
	end

	logic [CW-1:0] sel;
	always_comb begin
		case (c_q.channel)
			2'd0:    sel = rd_r;
			2'd1:    sel = rd_g;
			2'd2:    sel = rd_b;
			default: sel = rd_y;
		endcase
	end

	// bin count limited to the 24-bit result range before summing
	logic [31:0] sel32;
	logic [23:0] sel24;
	assign sel32 = 32'(sel);
	assign sel24 = (sel32 > 32'hFFFFFF) ? 24'hFFFFFF : sel32[23:0];

	logic        in_rng;
	logic [43:0] prod;
	assign in_rng = (idx_rd_q >= bidx(c_q.lo));
	assign prod   = 44'(idx_rd_q) * 44'(sel);

	always_ff @(posedge clk) begin
		if (take) c_q <= cmd;
		idx_rd_q <= ra;
		if (st_q == rgh_pkg::ST_QRD) begin
			rng_q <= '0;
			cum_q <= '0;
			int_q <= '0;
		end else if (st_q == rgh_pkg::ST_QACC && rvalid_q) begin
			cum_q <= (cum_q + 25'(sel24) > 25'hFFFFFF) ? 25'hFFFFFF : cum_q + 25'(sel24);
			if (in_rng) begin
				rng_q <= (rng_q + 25'(sel24) > 25'hFFFFFF) ? 25'hFFFFFF
					: rng_q + 25'(sel24);
				int_q <= (45'(int_q) + 45'(prod) > 45'hFFFFFFFF) ? 33'hFFFFFFFF
					: 33'(45'(int_q) + 45'(prod));
			end
		end
		if (st_q == rgh_pkg::ST_QOUT) begin
			out_data.range_count      <= rng_q[23:0];
			out_data.intensity_sum    <= int_q[31:0];
			out_data.cumulative_count <= cum_q[23:0];
			out_data.total_pixels     <= (33'(tot_q) > 33'hFFFFFF) ? 24'hFFFFFF
				: 24'(tot_q);
		end
	end
endmodule
